/* src/cfsp_pkg.sv */
// cfsp_pkg: shared types and codes of the class file stream parser
// no dependencies
package cfsp_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [4:0] {
    PH_MAGIC, PH_MINOR, PH_MAJOR, PH_POOLCNT, PH_TAG, PH_E16A, PH_E16B,
    PH_E32A, PH_E32B, PH_ULEN, PH_UBYTE, PH_REFKIND, PH_ACC, PH_THIS,
    PH_SUPER, PH_IFCNT, PH_IF, PH_FCNT, PH_MACC, PH_MNAME, PH_MDESC,
    PH_MACNT, PH_ANAME, PH_ALEN, PH_ADATA, PH_MCNT, PH_CACNT, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    SEC_HEADER, SEC_POOL, SEC_CLASS, SEC_IFACES, SEC_FIELDS, SEC_METHODS,
    SEC_ATTRS
  } section_e;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_OVERRUN, ERR_BAD_TAG
  } err_e;

  localparam logic [7:0] TagUtf8 = 8'd1;
  localparam logic [7:0] TagInt = 8'd3;
  localparam logic [7:0] TagFloat = 8'd4;
  localparam logic [7:0] TagLong = 8'd5;
  localparam logic [7:0] TagDouble = 8'd6;
  localparam logic [7:0] TagClass = 8'd7;
  localparam logic [7:0] TagString = 8'd8;
  localparam logic [7:0] TagFieldRef = 8'd9;
  localparam logic [7:0] TagMethodRef = 8'd10;
  localparam logic [7:0] TagIfMethodRef = 8'd11;
  localparam logic [7:0] TagNameType = 8'd12;
  localparam logic [7:0] TagMethodHandle = 8'd15;
  localparam logic [7:0] TagMethodType = 8'd16;
  localparam logic [7:0] TagInvokeDyn = 8'd18;

  typedef struct packed {
    logic [4:0]  field_kind;
    logic [31:0] field_value;
    logic [15:0] pool_slot;
    logic [7:0]  entry_tag;
    logic [2:0]  section;
    logic [1:0]  error_code;
    logic        class_done;
  } result_t;

endpackage

/* src/class_file_stream_parser.sv */
// class_file_stream_parser: top level, parser front end plus result queue
// depends on cfsp_pkg, cfsp_parser, cfsp_queue
//
// Takes a class file one byte per item and walks its layout (magic, versions,
// constant pool, class info, interfaces, fields, methods, class attributes).
// Every completed field and every raw payload byte gives one result item; an
// end of buffer before the class is complete gives an overrun item, after
// which bytes are ignored until reset, as are trailing bytes after the end.
// Rate: one byte per cycle while the result queue is not full; the parser
// updates its layout state once per byte, and a two-entry result queue keeps
// input flowing while an output item waits. Each result item is registered in the queue.
module class_file_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  field_kind_o,
  output logic [31:0] field_value_o,
  output logic [15:0] pool_slot_o,
  output logic [7:0]  entry_tag_o,
  output logic [2:0]  section_o,
  output logic [1:0]  error_code_o,
  output logic        class_done_o
);
  import cfsp_pkg::*;

  logic    take;
  logic    res_valid;
  logic    full;
  result_t res;
  result_t head;

  // stall only on a full queue, never on the output side directly
  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  cfsp_parser u_parser (
    .clk_i,
    .rst_ni,
    .take_i          (take),
    .data_byte_i,
    .end_of_buffer_i,
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  cfsp_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (head)
  );

  assign field_kind_o  = head.field_kind;
  assign field_value_o = head.field_value;
  assign pool_slot_o   = head.pool_slot;
  assign entry_tag_o   = head.entry_tag;
  assign section_o     = head.section;
  assign error_code_o  = head.error_code;
  assign class_done_o  = head.class_done;

endmodule

/* src/cfsp_parser.sv */
// cfsp_parser: front end, assembles fields byte by byte and walks the layout
// depends on cfsp_pkg
module cfsp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_buffer_i,
  output logic              res_valid_o,
  output cfsp_pkg::result_t res_o
);
  import cfsp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  bif_q, bif_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] pool_q, pool_d;
  logic [15:0] slot_q, slot_d;
  logic [15:0] mem_q, mem_d;
  logic [15:0] attr_q, attr_d;
  logic [31:0] pay_q, pay_d;
  logic [7:0]  tag_q, tag_d;
  logic        fin_q, fin_d;
  section_e    sec_q, sec_d;

  logic [31:0] acc_new;
  logic [1:0]  bif_inc;
  logic [2:0]  width;
  logic        complete;
  logic        done_now;
  logic        bad_tag;
  logic [15:0] v16;
  logic [15:0] pool_dec, mem_dec, attr_dec;
  logic [31:0] pay_dec;

  always_comb begin
    case (phase_q)
      PH_MAGIC, PH_E32A, PH_E32B, PH_ALEN: width = 3'd4;
      PH_TAG, PH_UBYTE, PH_REFKIND, PH_ADATA: width = 3'd1;
      default: width = 3'd2;
    endcase
  end

  assign acc_new  = {acc_q[23:0], data_byte_i};
  assign bif_inc  = bif_q + 2'd1;
  assign complete = (bif_inc == 2'd0) || ({1'b0, bif_inc} >= width);
  assign v16      = acc_new[15:0];
  assign pool_dec = pool_q - 16'd1;
  assign mem_dec  = mem_q - 16'd1;
  assign attr_dec = attr_q - 16'd1;
  assign pay_dec  = pay_q - 32'd1;

  always_comb begin
    phase_d = phase_q;
    bif_d = bif_q;
    acc_d = acc_q;
    pool_d = pool_q;
    slot_d = slot_q;
    mem_d = mem_q;
    attr_d = attr_q;
    pay_d = pay_q;
    tag_d = tag_q;
    fin_d = fin_q;
    sec_d = sec_q;
    done_now = 1'b0;
    bad_tag = 1'b0;
    res_valid_o = 1'b0;

    if (take_i && !fin_q) begin
      if (!complete) begin
        acc_d = acc_new;
        bif_d = bif_inc;
      end else begin
        acc_d = '0;
        bif_d = '0;
        if (phase_q == PH_TAG) tag_d = data_byte_i;
        case (phase_q)
          PH_MAGIC: phase_d = PH_MINOR;
          PH_MINOR: phase_d = PH_MAJOR;
          PH_MAJOR: begin
            phase_d = PH_POOLCNT;
            sec_d = SEC_POOL;
            slot_d = '0;
          end
          PH_POOLCNT: begin
            // a count of zero or one means an empty pool
            if (v16 <= 16'd1) begin
              pool_d = '0;
              phase_d = PH_ACC;
              sec_d = SEC_CLASS;
              slot_d = '0;
            end else begin
              pool_d = v16 - 16'd1;
              phase_d = PH_TAG;
            end
          end
          PH_TAG: begin
            case (data_byte_i)
              TagClass, TagString, TagMethodType, TagFieldRef, TagMethodRef,
              TagIfMethodRef, TagNameType, TagInvokeDyn: phase_d = PH_E16A;
              TagInt, TagFloat, TagLong, TagDouble: phase_d = PH_E32A;
              TagUtf8: phase_d = PH_ULEN;
              TagMethodHandle: phase_d = PH_REFKIND;
              default: begin
                bad_tag = 1'b1;
                phase_d = PH_E16B;
              end
            endcase
          end
          default: ;
        endcase

        // entry end handling, shared by the pool phases
        if (bad_tag || phase_q == PH_E16B || phase_q == PH_E32B ||
            (phase_q == PH_E16A && !(tag_q == TagFieldRef || tag_q == TagMethodRef ||
              tag_q == TagIfMethodRef || tag_q == TagNameType ||
              tag_q == TagInvokeDyn)) ||
            (phase_q == PH_E32A && !(tag_q == TagLong || tag_q == TagDouble)) ||
            (phase_q == PH_ULEN && v16 == 16'd0) ||
            (phase_q == PH_UBYTE && pay_dec == 32'd0)) begin
          slot_d = slot_q + 16'd1;
          pool_d = pool_dec;
          if (pool_dec == 16'd0) begin
            phase_d = PH_ACC;
            sec_d = SEC_CLASS;
            slot_d = '0;
          end else begin
            phase_d = PH_TAG;
          end
        end else begin
          case (phase_q)
            PH_E16A: phase_d = PH_E16B;
            PH_E32A: phase_d = PH_E32B;
            PH_ULEN: begin
              pay_d = {16'd0, v16};
              phase_d = PH_UBYTE;
            end
            PH_UBYTE: pay_d = pay_dec;
            PH_REFKIND: phase_d = PH_E16A;
            PH_ACC: phase_d = PH_THIS;
            PH_THIS: phase_d = PH_SUPER;
            PH_SUPER: begin
              phase_d = PH_IFCNT;
              sec_d = SEC_IFACES;
              slot_d = '0;
            end
            PH_IFCNT: begin
              mem_d = v16;
              if (v16 == 16'd0) begin
                phase_d = PH_FCNT;
                sec_d = SEC_FIELDS;
                slot_d = '0;
              end else begin
                phase_d = PH_IF;
              end
            end
            PH_IF: begin
              slot_d = slot_q + 16'd1;
              mem_d = mem_dec;
              if (mem_dec == 16'd0) begin
                phase_d = PH_FCNT;
                sec_d = SEC_FIELDS;
                slot_d = '0;
              end
            end
            PH_FCNT, PH_MCNT: begin
              mem_d = v16;
              if (v16 != 16'd0) begin
                phase_d = PH_MACC;
              end else if (phase_q == PH_FCNT) begin
                phase_d = PH_MCNT;
                sec_d = SEC_METHODS;
                slot_d = '0;
              end else begin
                phase_d = PH_CACNT;
                sec_d = SEC_ATTRS;
                slot_d = '0;
              end
            end
            PH_MACC: phase_d = PH_MNAME;
            PH_MNAME: phase_d = PH_MDESC;
            PH_MDESC: phase_d = PH_MACNT;
            PH_MACNT: begin
              attr_d = v16;
              if (v16 != 16'd0) phase_d = PH_ANAME;
            end
            PH_CACNT: begin
              attr_d = v16;
              if (v16 != 16'd0) phase_d = PH_ANAME;
            end
            PH_ANAME: phase_d = PH_ALEN;
            PH_ALEN: begin
              pay_d = acc_new;
              if (acc_new != 32'd0) phase_d = PH_ADATA;
            end
            PH_ADATA: pay_d = pay_dec;
            default: ;
          endcase

          // attribute end
          if ((phase_q == PH_ALEN && acc_new == 32'd0) ||
              (phase_q == PH_ADATA && pay_dec == 32'd0)) begin
            attr_d = attr_dec;
            if (sec_q == SEC_ATTRS) slot_d = slot_q + 16'd1;
            if (attr_dec != 16'd0) begin
              phase_d = PH_ANAME;
            end else if (sec_q == SEC_ATTRS) begin
              phase_d = PH_DONE;
              fin_d = 1'b1;
              done_now = 1'b1;
            end
          end
          if (phase_q == PH_CACNT && v16 == 16'd0) begin
            phase_d = PH_DONE;
            fin_d = 1'b1;
            done_now = 1'b1;
          end

          // member end
          if ((phase_q == PH_MACNT && v16 == 16'd0) ||
              (((phase_q == PH_ALEN && acc_new == 32'd0) ||
                (phase_q == PH_ADATA && pay_dec == 32'd0)) &&
               attr_dec == 16'd0 && sec_q != SEC_ATTRS)) begin
            slot_d = slot_q + 16'd1;
            mem_d = mem_dec;
            if (mem_dec != 16'd0) begin
              phase_d = PH_MACC;
            end else if (sec_q == SEC_FIELDS) begin
              phase_d = PH_MCNT;
              sec_d = SEC_METHODS;
              slot_d = '0;
            end else begin
              phase_d = PH_CACNT;
              sec_d = SEC_ATTRS;
              slot_d = '0;
            end
          end

          if (phase_q == PH_DONE) begin
            fin_d = 1'b1;
            done_now = 1'b1;
          end
        end
      end

      if (end_of_buffer_i && !done_now) begin
        fin_d = 1'b1;
        res_valid_o = 1'b1;
      end else begin
        res_valid_o = complete;
      end
    end
  end

  always_comb begin
    res_o.field_kind  = phase_q;
    res_o.field_value = complete ? acc_new : 32'd0;
    res_o.pool_slot   = slot_q;
    res_o.entry_tag   = (sec_q == SEC_POOL) ? tag_d : 8'd0;
    res_o.section     = sec_q;
    res_o.class_done  = done_now;
    if (end_of_buffer_i && !done_now) res_o.error_code = ERR_OVERRUN;
    else if (bad_tag) res_o.error_code = ERR_BAD_TAG;
    else res_o.error_code = ERR_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      bif_q <= '0;
      acc_q <= '0;
      pool_q <= '0;
      slot_q <= '0;
      mem_q <= '0;
      attr_q <= '0;
      pay_q <= '0;
      tag_q <= '0;
      fin_q <= 1'b0;
      sec_q <= SEC_HEADER;
    end else begin
      phase_q <= phase_d;
      bif_q <= bif_d;
      acc_q <= acc_d;
      pool_q <= pool_d;
      slot_q <= slot_d;
      mem_q <= mem_d;
      attr_q <= attr_d;
      pay_q <= pay_d;
      tag_q <= tag_d;
      fin_q <= fin_d;
      sec_q <= sec_d;
    end
  end

endmodule

/* src/cfsp_queue.sv */
// cfsp_queue: short result queue that feeds the output channel
// depends on cfsp_pkg
module cfsp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cfsp_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output cfsp_pkg::result_t data_o
);
  import cfsp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  result_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            pop;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == (PtrW + 1)'(QueueDepth);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW + 1)'(push_i) - (PtrW + 1)'(pop);
    end
  end

endmodule

/* src/cfsp_checker.sv */
// cfsp_checker: port-level assertions for the class file stream parser
// depends on cfsp_pkg; bound to class_file_stream_parser
module cfsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        end_of_buffer_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  field_kind_o,
  input logic [31:0] field_value_o,
  input logic [15:0] pool_slot_o,
  input logic [7:0]  entry_tag_o,
  input logic [2:0]  section_o,
  input logic [1:0]  error_code_o,
  input logic        class_done_o
);
  import cfsp_pkg::*;

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(data_byte_i) &&
    $stable(end_of_buffer_i))
    else $error("stalled input item changed");

  // a waiting result item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(field_value_o) &&
    $stable(field_kind_o))
    else $error("stalled result item changed");

  // an overrun never reports a finished class
  a_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == ERR_OVERRUN |-> !class_done_o)
    else $error("overrun flagged with class done");

  // tags only show inside the pool
  a_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && section_o != SEC_POOL |-> entry_tag_o == 8'd0)
    else $error("entry tag outside pool");

  // magic belongs to the header at slot zero
  a_magic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_kind_o == PH_MAGIC |-> section_o == SEC_HEADER &&
    pool_slot_o == 16'd0)
    else $error("magic outside header");

endmodule

bind class_file_stream_parser cfsp_checker u_cfsp_checker (.*);

/* verif/tb_class_file_stream_parser.sv */
// tb_class_file_stream_parser: self-checking bench for the class file walker
// depends on cfsp_pkg and class_file_stream_parser; builds one class file stream,
// walks it through a layout predictor and compares every result item
`timescale 1ns / 100ps

module tb_class_file_stream_parser;
  import cfsp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        end_of_buffer_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [4:0]  field_kind_o;
  logic [31:0] field_value_o;
  logic [15:0] pool_slot_o;
  logic [7:0]  entry_tag_o;
  logic [2:0]  section_o;
  logic [1:0]  error_code_o;
  logic        class_done_o;

  class_file_stream_parser i_dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // one byte of the stream, with a hand-written result where it is obvious
  typedef struct {
    logic [7:0] b;
    logic       eob;
    bit         typed;
    result_t    r;
  } stream_byte_t;

  typedef struct {
    logic [7:0]  b;
    bit          typed;
    phase_e      k;
    logic [31:0] v;
    logic [15:0] s;
    logic [7:0]  t;
    section_e    sec;
    err_e        e;
  } dir_row_t;

  localparam int RandEntries = 220;
  localparam int DirEntries = 5;
  localparam logic [15:0] PoolCount = 16'(1 + DirEntries + RandEntries);
  localparam int DirRows = 22;
  localparam int TailItems = 100;
  localparam int WatchdogLimit = 3000;

  // directed opening: header extremes, both unknown-tag extremes, a class ref,
  // an empty utf8 and a method handle with all-ones operands
  dir_row_t dir_tbl [DirRows] = '{
    '{8'hCA, 0, PH_MAGIC, 0, 0, 0, SEC_HEADER, ERR_NONE},
    '{8'hFE, 0, PH_MAGIC, 0, 0, 0, SEC_HEADER, ERR_NONE},
    '{8'hBA, 0, PH_MAGIC, 0, 0, 0, SEC_HEADER, ERR_NONE},
    '{8'hBE, 1, PH_MAGIC, 32'hCAFEBABE, 0, 0, SEC_HEADER, ERR_NONE},
    '{8'h00, 0, PH_MINOR, 0, 0, 0, SEC_HEADER, ERR_NONE},
    '{8'h00, 1, PH_MINOR, 0, 0, 0, SEC_HEADER, ERR_NONE},
    '{8'hFF, 0, PH_MAJOR, 0, 0, 0, SEC_HEADER, ERR_NONE},
    '{8'hFF, 1, PH_MAJOR, 32'h0000FFFF, 0, 0, SEC_HEADER, ERR_NONE},
    '{PoolCount[15:8], 0, PH_POOLCNT, 0, 0, 0, SEC_POOL, ERR_NONE},
    '{PoolCount[7:0], 1, PH_POOLCNT, 32'(PoolCount), 0, 0, SEC_POOL, ERR_NONE},
    '{8'h00, 1, PH_TAG, 0, 0, 0, SEC_POOL, ERR_BAD_TAG},
    '{8'hFF, 1, PH_TAG, 32'hFF, 1, 8'hFF, SEC_POOL, ERR_BAD_TAG},
    '{TagClass, 0, PH_TAG, 0, 0, 0, SEC_POOL, ERR_NONE},
    '{8'h00, 0, PH_TAG, 0, 0, 0, SEC_POOL, ERR_NONE},
    '{8'h01, 0, PH_TAG, 0, 0, 0, SEC_POOL, ERR_NONE},
    '{TagUtf8, 0, PH_TAG, 0, 0, 0, SEC_POOL, ERR_NONE},
    '{8'h00, 0, PH_TAG, 0, 0, 0, SEC_POOL, ERR_NONE},
    '{8'h00, 0, PH_TAG, 0, 0, 0, SEC_POOL, ERR_NONE},
    '{TagMethodHandle, 0, PH_TAG, 0, 0, 0, SEC_POOL, ERR_NONE},
    '{8'hFF, 0, PH_TAG, 0, 0, 0, SEC_POOL, ERR_NONE},
    '{8'hFF, 0, PH_TAG, 0, 0, 0, SEC_POOL, ERR_NONE},
    '{8'hFF, 0, PH_TAG, 0, 0, 0, SEC_POOL, ERR_NONE}
  };

  stream_byte_t class_bytes[$];
  result_t      pending_fields[$];
  bit           failed = 1'b0;
  int           sent_cnt = 0;
  int           walked_cnt = 0;

  // ---------------------------------------------------------------------------
  // layout predictor: own copy of the walker state
  // ---------------------------------------------------------------------------
  phase_e      cur_phase = PH_MAGIC;
  logic [1:0]  field_pos = '0;
  logic [31:0] assembled = '0;
  logic [15:0] entries_left = '0;
  logic [15:0] slot_cnt = '0;
  logic [15:0] members_left = '0;
  logic [15:0] attrs_left = '0;
  logic [31:0] payload_left = '0;
  logic [7:0]  tag_now = '0;
  bit          walk_stopped = 1'b0;
  section_e    cur_sec = SEC_HEADER;
  bit          just_completed = 1'b0;

  function automatic int unsigned field_bytes(phase_e p);
    case (p)
      PH_MAGIC, PH_E32A, PH_E32B, PH_ALEN: return 4;
      PH_TAG, PH_UBYTE, PH_REFKIND, PH_ADATA: return 1;
      default: return 2;
    endcase
  endfunction

  function automatic bit known_tag(logic [7:0] t);
    return t inside {TagUtf8, TagInt, TagFloat, TagLong, TagDouble, TagClass, TagString,
                     TagFieldRef, TagMethodRef, TagIfMethodRef, TagNameType,
                     TagMethodHandle, TagMethodType, TagInvokeDyn};
  endfunction

  function void open_count(phase_e p, section_e s);
    cur_phase = p;
    cur_sec = s;
    slot_cnt = '0;
  endfunction

  function void close_class();
    cur_phase = PH_DONE;
    walk_stopped = 1'b1;
    just_completed = 1'b1;
  endfunction

  function void next_entry();
    slot_cnt = slot_cnt + 16'd1;
    entries_left = entries_left - 16'd1;
    if (entries_left == 0) begin
      cur_phase = PH_ACC;
      cur_sec = SEC_CLASS;
      slot_cnt = '0;
    end else begin
      cur_phase = PH_TAG;
    end
  endfunction

  function void next_member();
    slot_cnt = slot_cnt + 16'd1;
    members_left = members_left - 16'd1;
    if (members_left != 0) cur_phase = PH_MACC;
    else if (cur_sec == SEC_FIELDS) open_count(PH_MCNT, SEC_METHODS);
    else open_count(PH_CACNT, SEC_ATTRS);
  endfunction

  function void next_attr();
    attrs_left = attrs_left - 16'd1;
    if (cur_sec == SEC_ATTRS) slot_cnt = slot_cnt + 16'd1;
    if (attrs_left != 0) cur_phase = PH_ANAME;
    else if (cur_sec == SEC_ATTRS) close_class();
    else next_member();
  endfunction

  // moves on after a completed field; returns 1 on an unknown pool tag
  function bit step_layout(logic [31:0] v);
    logic [15:0] v16;
    bit fcnt;
    v16 = v[15:0];
    case (cur_phase)
      PH_MAGIC: cur_phase = PH_MINOR;
      PH_MINOR: cur_phase = PH_MAJOR;
      PH_MAJOR: open_count(PH_POOLCNT, SEC_POOL);
      PH_POOLCNT: begin
        entries_left = (v16 == 0) ? 16'd0 : v16 - 16'd1;
        cur_phase = PH_TAG;
        if (entries_left == 0) begin
          entries_left = 16'd1;
          slot_cnt = slot_cnt - 16'd1;
          next_entry();
        end
      end
      PH_TAG: begin
        if (tag_now inside {TagClass, TagString, TagMethodType, TagFieldRef, TagMethodRef,
                            TagIfMethodRef, TagNameType, TagInvokeDyn}) cur_phase = PH_E16A;
        else if (tag_now inside {TagInt, TagFloat, TagLong, TagDouble}) cur_phase = PH_E32A;
        else if (tag_now == TagUtf8) cur_phase = PH_ULEN;
        else if (tag_now == TagMethodHandle) cur_phase = PH_REFKIND;
        else begin
          next_entry();
          return 1'b1;
        end
      end
      PH_E16A: begin
        if (tag_now inside {TagFieldRef, TagMethodRef, TagIfMethodRef, TagNameType,
                            TagInvokeDyn}) cur_phase = PH_E16B;
        else next_entry();
      end
      PH_E16B, PH_E32B: next_entry();
      PH_E32A: begin
        if (tag_now == TagLong || tag_now == TagDouble) cur_phase = PH_E32B;
        else next_entry();
      end
      PH_ULEN: begin
        payload_left = 32'(v16);
        if (payload_left == 0) next_entry(); else cur_phase = PH_UBYTE;
      end
      PH_UBYTE: begin
        payload_left = payload_left - 32'd1;
        if (payload_left == 0) next_entry();
      end
      PH_REFKIND: cur_phase = PH_E16A;
      PH_ACC: cur_phase = PH_THIS;
      PH_THIS: cur_phase = PH_SUPER;
      PH_SUPER: open_count(PH_IFCNT, SEC_IFACES);
      PH_IFCNT: begin
        members_left = v16;
        if (members_left == 0) open_count(PH_FCNT, SEC_FIELDS); else cur_phase = PH_IF;
      end
      PH_IF: begin
        slot_cnt = slot_cnt + 16'd1;
        members_left = members_left - 16'd1;
        if (members_left == 0) open_count(PH_FCNT, SEC_FIELDS);
      end
      PH_FCNT, PH_MCNT: begin
        fcnt = (cur_phase == PH_FCNT);
        members_left = v16;
        if (members_left != 0) cur_phase = PH_MACC;
        else if (fcnt) open_count(PH_MCNT, SEC_METHODS);
        else open_count(PH_CACNT, SEC_ATTRS);
      end
      PH_MACC: cur_phase = PH_MNAME;
      PH_MNAME: cur_phase = PH_MDESC;
      PH_MDESC: cur_phase = PH_MACNT;
      PH_MACNT: begin
        attrs_left = v16;
        if (attrs_left == 0) next_member(); else cur_phase = PH_ANAME;
      end
      PH_CACNT: begin
        attrs_left = v16;
        if (attrs_left == 0) close_class(); else cur_phase = PH_ANAME;
      end
      PH_ANAME: cur_phase = PH_ALEN;
      PH_ALEN: begin
        payload_left = v;
        if (payload_left == 0) next_attr(); else cur_phase = PH_ADATA;
      end
      PH_ADATA: begin
        payload_left = payload_left - 32'd1;
        if (payload_left == 0) next_attr();
      end
      default: close_class();
    endcase
    return 1'b0;
  endfunction

  // takes one byte; returns 1 and the field item when one is due
  function bit walk_byte(logic [7:0] b, logic eob, output result_t r);
    phase_e      kind;
    section_e    sec;
    logic [15:0] slot;
    logic [31:0] value;
    err_e        err;
    bit          completed;
    kind = cur_phase;
    sec = cur_sec;
    slot = slot_cnt;
    value = '0;
    err = ERR_NONE;
    completed = 1'b0;
    r = '0;
    if (walk_stopped) return 1'b0;
    just_completed = 1'b0;
    assembled = {assembled[23:0], b};
    field_pos = field_pos + 2'd1;
    if (field_pos == 0 || field_pos >= field_bytes(cur_phase)) begin
      completed = 1'b1;
      value = assembled;
      assembled = '0;
      field_pos = '0;
      if (cur_phase == PH_TAG) tag_now = value[7:0];
      if (step_layout(value)) err = ERR_BAD_TAG;
    end
    if (eob && !just_completed) begin
      // early end of buffer: overrun wins over everything, then the walk stops
      err = ERR_OVERRUN;
      walk_stopped = 1'b1;
      if (!completed) value = '0;
    end else if (!completed) begin
      return 1'b0;
    end
    r.field_kind = kind;
    r.field_value = value;
    r.pool_slot = slot;
    r.entry_tag = (sec == SEC_POOL) ? tag_now : 8'd0;
    r.section = sec;
    r.error_code = err;
    r.class_done = just_completed;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stream builder
  // ---------------------------------------------------------------------------
  task automatic put8(logic [7:0] b);
    stream_byte_t it;
    it.b = b;
    it.eob = 1'b0;
    it.typed = 1'b0;
    it.r = '0;
    class_bytes.push_back(it);
  endtask

  task automatic put16(logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endtask

  task automatic put32(logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endtask

  task automatic put_rand(int n);
    for (int i = 0; i < n; i++) put8(8'($urandom_range(0, 255)));
  endtask

  task automatic put_attrs(int n);
    int len;
    for (int i = 0; i < n; i++) begin
      len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
      put16(16'($urandom));
      put32(32'(len));
      put_rand(len);
    end
  endtask

  task automatic put_members();
    int n;
    int na;
    n = $urandom_range(0, 6);
    put16(16'(n));
    for (int i = 0; i < n; i++) begin
      put_rand(6);
      na = $urandom_range(0, 3);
      put16(16'(na));
      put_attrs(na);
    end
  endtask

  task automatic build_class();
    stream_byte_t it;
    logic [7:0] t;
    logic [7:0] known [14];
    int n;
    int cut;
    known = '{TagUtf8, TagInt, TagFloat, TagLong, TagDouble, TagClass, TagString,
              TagFieldRef, TagMethodRef, TagIfMethodRef, TagNameType,
              TagMethodHandle, TagMethodType, TagInvokeDyn};
    foreach (dir_tbl[i]) begin
      it.b = dir_tbl[i].b;
      it.eob = 1'b0;
      it.typed = dir_tbl[i].typed;
      it.r = '{dir_tbl[i].k, dir_tbl[i].v, dir_tbl[i].s, dir_tbl[i].t, dir_tbl[i].sec,
               dir_tbl[i].e, 1'b0};
      class_bytes.push_back(it);
    end
    // random pool entries, mostly well formed
    for (int i = 0; i < RandEntries; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        do t = 8'($urandom_range(0, 255)); while (known_tag(t));
      end else begin
        t = known[$urandom_range(0, 13)];
      end
      put8(t);
      case (t)
        TagUtf8: begin
          n = $urandom_range(0, 6);
          put16(16'(n));
          put_rand(n);
        end
        TagInt, TagFloat, TagFieldRef, TagMethodRef, TagIfMethodRef, TagNameType,
        TagInvokeDyn: put_rand(4);
        TagLong, TagDouble: put_rand(8);
        TagClass, TagString, TagMethodType: put_rand(2);
        TagMethodHandle: put_rand(3);
        default: ;
      endcase
    end
    put_rand(6);
    n = $urandom_range(0, 4);
    put16(16'(n));
    put_rand(2 * n);
    put_members();
    put_members();
    n = $urandom_range(0, 4);
    put16(16'(n));
    put_attrs(n);
    // end either cleanly or with an early end of buffer, then trailing noise
    if ($urandom_range(0, 1) == 0) begin
      cut = $urandom_range(class_bytes.size() / 2, class_bytes.size() - 1);
      while (class_bytes.size() > cut) void'(class_bytes.pop_back());
    end
    class_bytes[class_bytes.size() - 1].eob = 1'b1;
    for (int i = 0; i < 20; i++) begin
      put8(8'($urandom_range(0, 255)));
      class_bytes[class_bytes.size() - 1].eob = 1'($urandom_range(0, 1));
    end
  endtask

  // no idling in the last stretch, nor in every third window of 128 items
  function automatic bit quiet();
    return (sent_cnt >= class_bytes.size() - TailItems) || ((sent_cnt / 128) % 3 == 0);
  endfunction

  // ---------------------------------------------------------------------------
  // byte sender
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    logic nxt_valid;
    gap = 0;
    build_class();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) sent_cnt++;
      // a stalled item holds still
      if (!(in_valid_i && in_stall_o)) begin
        if (sent_cnt >= class_bytes.size()) begin
          nxt_valid = 1'b0;
        end else if (gap > 0) begin
          gap--;
          nxt_valid = 1'b0;
        end else if (!quiet() && $urandom_range(0, 7) == 0) begin
          gap = $urandom_range(1, 14) - 1;
          nxt_valid = 1'b0;
        end else begin
          nxt_valid = 1'b1;
          data_byte_i <= class_bytes[sent_cnt].b;
          end_of_buffer_i <= class_bytes[sent_cnt].eob;
        end
        in_valid_i <= nxt_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stall bursts plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    bit pressed;
    hold = 0;
    pressed = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) hold--;
      else if (!pressed && sent_cnt >= 250) begin
        // long hold-off so the result queue fills and the input backs up
        pressed = 1'b1;
        hold = 300;
      end else if (!quiet() && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 14);
      out_stall_i <= (hold > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on accepted bytes, check on accepted results
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      failed = 1'b1;
    end
  endtask

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    result_t r;
    result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (walk_byte(data_byte_i, end_of_buffer_i, r)) begin
          if (class_bytes[walked_cnt].typed) r = class_bytes[walked_cnt].r;
          pending_fields.push_back(r);
        end
        walked_cnt++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_fields.size() == 0) begin
          $error("result item with nothing expected: kind %0d value %0h",
                 field_kind_o, field_value_o);
          failed = 1'b1;
        end else begin
          want = pending_fields.pop_front();
          check_field("field_kind", want.field_kind, field_kind_o);
          check_field("field_value", want.field_value, field_value_o);
          check_field("pool_slot", want.pool_slot, pool_slot_o);
          check_field("entry_tag", want.entry_tag, entry_tag_o);
          check_field("section", want.section, section_o);
          check_field("error_code", want.error_code, error_code_o);
          check_field("class_done", want.class_done, class_done_o);
        end
      end
      // watchdog on cycles with no handshake on either side
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // end of run
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    while (sent_cnt < class_bytes.size() || pending_fields.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed && pending_fields.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
